// File: rtl/bam_pkg.sv
package bam_pkg;

  // Fixed field widths
  localparam int RES_W    = 24;   // result code and calibration width
  localparam int WAIT_W   = 20;   // conversion delay counter width
  localparam int AVGC_W   = 5;    // average count register width
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_FAST   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_WAIT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_WAIT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_CNT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_CODE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MASS_DIVISOR = 3'd5;

  // Reset values
  localparam logic              RST_SPEED_FAST   = 1'b1;
  localparam logic [WAIT_W-1:0] RST_FAST_WAIT    = 20'd26000;
  localparam logic [WAIT_W-1:0] RST_SLOW_WAIT    = 20'd200000;
  localparam logic [AVGC_W-1:0] RST_AVERAGE_CNT  = 5'd1;
  localparam logic [RES_W-1:0]  RST_ZERO_CODE    = 24'd12500;
  localparam logic [RES_W-1:0]  RST_MASS_DIVISOR = 24'd71;

  typedef struct packed {
    logic              speed_fast;
    logic [WAIT_W-1:0] fast_wait_ticks;
    logic [WAIT_W-1:0] slow_wait_ticks;
    logic [AVGC_W-1:0] average_count;
    logic [RES_W-1:0]  zero_code;
    logic [RES_W-1:0]  mass_divisor;
  } bam_cfg_t;

  // Readout phase of the converter interface
  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_WAIT = 4'b0010,
    PH_BITS = 4'b0100,
    PH_TAIL = 4'b1000
  } bam_phase_t;

  // Sequencer around the shared divider
  typedef enum logic [2:0] {
    SQ_TICK = 3'b001,
    SQ_AVG  = 3'b010,
    SQ_MASS = 3'b100
  } bam_seq_t;

endpackage

// File: rtl/bam_cfg.sv
module bam_cfg
  import bam_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output bam_cfg_t              cfg
);

  bam_cfg_t regs;

  // Register file, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.speed_fast      <= RST_SPEED_FAST;
      regs.fast_wait_ticks <= RST_FAST_WAIT;
      regs.slow_wait_ticks <= RST_SLOW_WAIT;
      regs.average_count   <= RST_AVERAGE_CNT;
      regs.zero_code       <= RST_ZERO_CODE;
      regs.mass_divisor    <= RST_MASS_DIVISOR;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SPEED_FAST:   regs.speed_fast      <= cfg_data[0];
        REG_FAST_WAIT:    regs.fast_wait_ticks <= cfg_data[WAIT_W-1:0];
        REG_SLOW_WAIT:    regs.slow_wait_ticks <= cfg_data[WAIT_W-1:0];
        REG_AVERAGE_CNT:  regs.average_count   <= cfg_data[AVGC_W-1:0];
        REG_ZERO_CODE:    regs.zero_code       <= cfg_data[RES_W-1:0];
        REG_MASS_DIVISOR: regs.mass_divisor    <= cfg_data[RES_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

// File: rtl/bam_div.sv
module bam_div
  import bam_pkg::*;
#(
  parameter int N = 29,
  parameter int D = 24
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic         done,
  output logic [N-1:0] quotient
);

  localparam int CNT_W = $clog2(N + 1);

  logic [N-1:0]     dvd;
  logic [D-1:0]     dsr;
  logic [D-1:0]     rem;
  logic [CNT_W-1:0] count;
  logic [D:0]       rem_sh;
  logic             fits;

  // One restoring step: shift in next dividend bit, trial subtract
  assign rem_sh = {rem, dvd[N-1]};
  assign fits   = (rem_sh >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else if (start) begin
      count <= CNT_W'(N);
      done  <= 1'b0;
    end else if (count != '0) begin
      count <= count - 1'b1;
      done  <= (count == CNT_W'(1));
    end else begin
      done  <= 1'b0;
    end
  end

  // Datapath, the dividend register fills with quotient bits
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (count != '0) begin
      dvd <= {dvd[N-2:0], fits};
      rem <= fits ? D'(rem_sh - {1'b0, dsr}) : rem_sh[D-1:0];
    end
  end

  assign quotient = dvd;

endmodule

// File: rtl/bridge_adc_readout_mass.sv
// Channel | Signals                       | Transaction
// in      | in_valid, in_ready            | one tick: start_req, dout_level
// out     | out_valid, out_ready          | one tick result: pins, status, code, mass
// cfg     | cfg_we, cfg_index, cfg_data   | one register write, no wait
//
// An ordinary tick: once accepted, its result is registered at the next edge.
// The final tick of a measurement runs the shared restoring divider on the average,
// then on the mass unless the average is below the zero code, one quotient bit a
// cycle; DIV_W = max(CODE_BITS + clog2(MAX_AVERAGE + 1), 24), 29 with defaults.
// in_ready is low while dividing or while a result is held and not taken.
// rst is synchronous and returns the readout to idle with reset register values.
module bridge_adc_readout_mass
  import bam_pkg::*;
#(
  parameter int CODE_BITS   = 24,
  parameter int MAX_AVERAGE = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  start_req,
  input  logic                  dout_level,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  sclk_level,
  output logic                  speed_level,
  output logic                  busy_res,
  output logic                  done_res,
  output logic [RES_W-1:0]      average_code,
  output logic [RES_W-1:0]      mass_value,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_AVERAGE + 1);
  localparam int BIT_W = $clog2(CODE_BITS + 1);
  localparam int SUM_W = CODE_BITS + CNT_W;
  localparam int DIV_W = (SUM_W > RES_W) ? SUM_W : RES_W;

  bam_cfg_t cfg;

  bam_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Readout state
  bam_phase_t       phase, phase_next;
  logic [WAIT_W-1:0] wait_counter, wait_counter_next;
  logic [BIT_W-1:0]  bit_counter, bit_counter_next;
  logic [CODE_BITS-1:0] shift_value, shift_value_next;
  logic [CNT_W-1:0]  sample_counter, sample_counter_next;
  logic [SUM_W-1:0]  sample_sum, sample_sum_next;
  logic              clock_high, clock_high_next;
  logic              tick_final;

  bam_seq_t          seq;
  logic              accept;
  logic [DIV_W-1:0]  avg_res;

  // Divider interface
  logic              div_start;
  logic [DIV_W-1:0]  div_dividend;
  logic [RES_W-1:0]  div_divisor;
  logic              div_done;
  logic [DIV_W-1:0]  div_quotient;

  logic [WAIT_W-1:0] wait_load;
  logic [31:0]       avg_cnt32;
  logic [CNT_W-1:0]  eff_count;
  logic [BIT_W-1:0]  bit_inc;
  logic [CNT_W-1:0]  cnt_inc;
  logic [RES_W-1:0]  divisor_eff;
  logic              avg_ge_zero;

  // Delay and sample count with their special cases
  always_comb begin
    wait_load = cfg.speed_fast ? cfg.fast_wait_ticks : cfg.slow_wait_ticks;
    if (wait_load == '0) wait_load = WAIT_W'(1);
    avg_cnt32 = 32'(cfg.average_count);
    if (avg_cnt32 == 32'd0) begin
      eff_count = CNT_W'(1);
    end else if (avg_cnt32 > 32'(MAX_AVERAGE)) begin
      eff_count = CNT_W'(MAX_AVERAGE);
    end else begin
      eff_count = CNT_W'(avg_cnt32);
    end
  end

  assign bit_inc = bit_counter + 1'b1;
  assign cnt_inc = sample_counter + 1'b1;

  // Next readout state for one tick
  always_comb begin
    phase_next          = phase;
    wait_counter_next   = wait_counter;
    bit_counter_next    = bit_counter;
    shift_value_next    = shift_value;
    sample_counter_next = sample_counter;
    sample_sum_next     = sample_sum;
    clock_high_next     = clock_high;
    tick_final          = 1'b0;
    case (phase)
      PH_IDLE: begin
        if (start_req) begin
          sample_sum_next     = '0;
          sample_counter_next = '0;
          clock_high_next     = 1'b0;
          wait_counter_next   = wait_load;
          phase_next          = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (wait_counter <= WAIT_W'(1)) begin
          wait_counter_next = '0;
          bit_counter_next  = '0;
          shift_value_next  = '0;
          clock_high_next   = 1'b0;
          phase_next        = PH_BITS;
        end else begin
          wait_counter_next = wait_counter - 1'b1;
        end
      end
      PH_BITS: begin
        if (!clock_high) begin
          clock_high_next = 1'b1;
        end else begin
          clock_high_next  = 1'b0;
          shift_value_next = {shift_value[CODE_BITS-2:0], dout_level};
          bit_counter_next = bit_inc;
          if (bit_inc >= BIT_W'(CODE_BITS)) phase_next = PH_TAIL;
        end
      end
      PH_TAIL: begin
        if (!clock_high) begin
          clock_high_next = 1'b1;
        end else begin
          clock_high_next     = 1'b0;
          sample_sum_next     = sample_sum + SUM_W'(shift_value);
          sample_counter_next = cnt_inc;
          if (cnt_inc >= eff_count) begin
            tick_final = 1'b1;
            phase_next = PH_IDLE;
          end else begin
            wait_counter_next = wait_load;
            phase_next        = PH_WAIT;
          end
        end
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  assign in_ready = (seq == SQ_TICK) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      wait_counter   <= '0;
      bit_counter    <= '0;
      shift_value    <= '0;
      sample_counter <= '0;
      sample_sum     <= '0;
      clock_high     <= 1'b0;
    end else if (accept) begin
      phase          <= phase_next;
      wait_counter   <= wait_counter_next;
      bit_counter    <= bit_counter_next;
      shift_value    <= shift_value_next;
      sample_counter <= sample_counter_next;
      sample_sum     <= sample_sum_next;
      clock_high     <= clock_high_next;
    end
  end

  // Divider operand selection: average first, then mass
  assign divisor_eff = (cfg.mass_divisor == '0) ? RES_W'(1) : cfg.mass_divisor;
  assign avg_ge_zero = (div_quotient >= DIV_W'(cfg.zero_code));

  always_comb begin
    div_start    = 1'b0;
    div_dividend = DIV_W'(sample_sum_next);
    div_divisor  = RES_W'(sample_counter_next);
    case (seq)
      SQ_TICK: div_start = accept && tick_final;
      SQ_AVG: begin
        div_dividend = div_quotient - DIV_W'(cfg.zero_code);
        div_divisor  = divisor_eff;
        div_start    = div_done && avg_ge_zero;
      end
      default: ;
    endcase
  end

  bam_div #(
    .N (DIV_W),
    .D (RES_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= SQ_TICK;
    end else begin
      case (seq)
        SQ_TICK: if (accept && tick_final) seq <= SQ_AVG;
        SQ_AVG:  if (div_done) seq <= avg_ge_zero ? SQ_MASS : SQ_TICK;
        SQ_MASS: if (div_done) seq <= SQ_TICK;
        default: seq <= SQ_TICK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (seq == SQ_AVG && div_done) avg_res <= div_quotient;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (accept && !tick_final) out_valid <= 1'b1;
      if (seq == SQ_AVG && div_done && !avg_ge_zero) out_valid <= 1'b1;
      if (seq == SQ_MASS && div_done) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sclk_level   <= clock_high_next;
      speed_level  <= cfg.speed_fast;
      busy_res     <= (phase_next != PH_IDLE);
      done_res     <= tick_final;
      average_code <= '0;
      mass_value   <= '0;
    end else if (seq == SQ_AVG && div_done) begin
      average_code <= div_quotient[RES_W-1:0];
      mass_value   <= '0;
    end else if (seq == SQ_MASS && div_done) begin
      average_code <= avg_res[RES_W-1:0];
      mass_value   <= div_quotient[RES_W-1:0];
    end
  end

endmodule

// File: rtl/bam_chk.sv
module bam_chk
  import bam_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic             sclk_level,
  input logic             busy_res,
  input logic             done_res,
  input logic [RES_W-1:0] average_code,
  input logic [RES_W-1:0] mass_value
);

  // A finished measurement leaves the readout idle with the clock low
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res && !sclk_level)
    else $error("done transaction with busy or clock high");

  // Code and mass are zero on every ordinary tick
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !done_res |-> average_code == '0 && mass_value == '0)
    else $error("nonzero result fields without done");

  // A tick accepted while idle with no result pending shows up next cycle
  a_tick_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid && !busy_res |=> out_valid)
    else $error("tick result missing");

  // A held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(average_code)
      && $stable(mass_value) && $stable(done_res))
    else $error("result changed while stalled");

endmodule

bind bridge_adc_readout_mass bam_chk u_bam_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .sclk_level   (sclk_level),
  .busy_res     (busy_res),
  .done_res     (done_res),
  .average_code (average_code),
  .mass_value   (mass_value)
);

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import bam_pkg::*;

  localparam int SAMPLE_BITS   = 24;
  localparam int AVG_LIMIT     = 16;
  localparam int SUM_W         = RES_W + 5;
  localparam int GAP_MAX       = 12;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int SETTLE_CYCLES = 150;

  typedef enum {DATA_RANDOM, DATA_ONES, DATA_ZEROS} data_mode_t;

  // One tick result as the block should present it
  typedef struct {
    logic             sclk;
    logic             speed;
    logic             busy;
    logic             done;
    logic [RES_W-1:0] avg;
    logic [RES_W-1:0] mass;
  } tick_res_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic                  start_req;
  logic                  dout_level;
  logic                  out_valid;
  logic                  out_ready;
  logic                  sclk_level;
  logic                  speed_level;
  logic                  busy_res;
  logic                  done_res;
  logic [RES_W-1:0]      average_code;
  logic [RES_W-1:0]      mass_value;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bridge_adc_readout_mass #(
    .CODE_BITS   (SAMPLE_BITS),
    .MAX_AVERAGE (AVG_LIMIT)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .start_req    (start_req),
    .dout_level   (dout_level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sclk_level   (sclk_level),
    .speed_level  (speed_level),
    .busy_res     (busy_res),
    .done_res     (done_res),
    .average_code (average_code),
    .mass_value   (mass_value),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Readout predictor state and its copy of the registers
  bam_cfg_t              cal_regs;
  bam_phase_t            rd_phase;
  logic [WAIT_W-1:0]     rd_wait;
  int                    rd_bits;
  logic [SAMPLE_BITS-1:0] rd_shift;
  int                    rd_samples;
  logic [SUM_W-1:0]      rd_sum;
  logic                  rd_clk;

  tick_res_t tick_results_due[$];
  int        mismatches = 0;
  int        items_sent;
  int        rx_wait;
  bit        tx_calm;
  bit        rx_calm;
  bit        tx_holding;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  function automatic int next_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, GAP_MAX);
  endfunction

  function automatic void reset_model();
    cal_regs.speed_fast      = RST_SPEED_FAST;
    cal_regs.fast_wait_ticks = RST_FAST_WAIT;
    cal_regs.slow_wait_ticks = RST_SLOW_WAIT;
    cal_regs.average_count   = RST_AVERAGE_CNT;
    cal_regs.zero_code       = RST_ZERO_CODE;
    cal_regs.mass_divisor    = RST_MASS_DIVISOR;
    rd_phase   = PH_IDLE;
    rd_wait    = '0;
    rd_bits    = 0;
    rd_shift   = '0;
    rd_samples = 0;
    rd_sum     = '0;
    rd_clk     = 1'b0;
  endfunction

  // Conversion delay for the next sample; zero counts as one tick
  function automatic void reload_wait();
    logic [WAIT_W-1:0] w;
    w = cal_regs.speed_fast ? cal_regs.fast_wait_ticks : cal_regs.slow_wait_ticks;
    rd_wait = (w == '0) ? WAIT_W'(1) : w;
  endfunction

  function automatic int samples_wanted();
    int c;
    c = cal_regs.average_count;
    if (c == 0) c = 1;
    if (c > AVG_LIMIT) c = AVG_LIMIT;
    return c;
  endfunction

  // Advance the readout by one tick and return what the block should report
  function automatic tick_res_t step_readout(input logic req, input logic pin);
    tick_res_t        r;
    logic [SUM_W-1:0] quot;
    logic [RES_W-1:0] divisor;
    r.avg  = '0;
    r.mass = '0;
    r.done = 1'b0;
    case (rd_phase)
      PH_IDLE: begin
        if (req) begin
          rd_sum     = '0;
          rd_samples = 0;
          rd_clk     = 1'b0;
          reload_wait();
          rd_phase   = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (rd_wait <= 1) begin
          rd_wait  = '0;
          rd_bits  = 0;
          rd_shift = '0;
          rd_clk   = 1'b0;
          rd_phase = PH_BITS;
        end else begin
          rd_wait = rd_wait - 1'b1;
        end
      end
      PH_BITS: begin
        // high tick, then low tick with the data bit shifted in, MSB first
        if (!rd_clk) begin
          rd_clk = 1'b1;
        end else begin
          rd_clk   = 1'b0;
          rd_shift = {rd_shift[SAMPLE_BITS-2:0], pin};
          rd_bits++;
          if (rd_bits >= SAMPLE_BITS) rd_phase = PH_TAIL;
        end
      end
      PH_TAIL: begin
        if (!rd_clk) begin
          rd_clk = 1'b1;
        end else begin
          rd_clk = 1'b0;
          rd_sum = rd_sum + SUM_W'(rd_shift);
          rd_samples++;
          if (rd_samples >= samples_wanted()) begin
            divisor = (cal_regs.mass_divisor == '0) ? RES_W'(1) : cal_regs.mass_divisor;
            quot    = rd_sum / SUM_W'(rd_samples);
            r.avg   = quot[RES_W-1:0];
            r.mass  = (r.avg >= cal_regs.zero_code) ?
                      (r.avg - cal_regs.zero_code) / divisor : '0;
            r.done   = 1'b1;
            rd_phase = PH_IDLE;
          end else begin
            reload_wait();
            rd_phase = PH_WAIT;
          end
        end
      end
      default: ;
    endcase
    r.sclk  = rd_clk;
    r.speed = cal_regs.speed_fast;
    r.busy  = (rd_phase != PH_IDLE);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [RES_W-1:0] want,
                                      input logic [RES_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Result side: random stalls on out_ready, each transaction checked in order
  always @(posedge clk) begin
    tick_res_t want;
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (tick_results_due.size() == 0) begin
          $error("result transaction with no tick outstanding");
          mismatches++;
        end else begin
          want = tick_results_due.pop_front();
          check_field("sclk_level", RES_W'(want.sclk), RES_W'(sclk_level));
          check_field("speed_level", RES_W'(want.speed), RES_W'(speed_level));
          check_field("busy_res", RES_W'(want.busy), RES_W'(busy_res));
          check_field("done_res", RES_W'(want.done), RES_W'(done_res));
          check_field("average_code", want.avg, average_code);
          check_field("mass_value", want.mass, mass_value);
        end
        rx_wait = next_gap(rx_calm);
        if (rx_wait != 0) out_ready <= 1'b0;
      end else if (!out_ready) begin
        if (rx_wait <= 1) out_ready <= 1'b1;
        if (rx_wait > 0) rx_wait--;
      end
    end
  end

  task automatic lower_valid();
    if (tx_holding) begin
      in_valid   <= 1'b0;
      tx_holding = 1'b0;
    end
  endtask

  // One tick transaction; valid is left high so a following tick can go back to back
  task automatic send_tick(input logic req, input logic pin);
    int gap;
    gap = next_gap(tx_calm);
    if (gap > 0) begin
      lower_valid();
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    start_req  <= req;
    dout_level <= pin;
    tx_holding = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tick_results_due.push_back(step_readout(req, pin));
    items_sent++;
  endtask

  // Hold off the sender until every outstanding result has been taken
  task automatic drain();
    lower_valid();
    while (tick_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    drain();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SPEED_FAST:   cal_regs.speed_fast      = val[0];
      REG_FAST_WAIT:    cal_regs.fast_wait_ticks = val[WAIT_W-1:0];
      REG_SLOW_WAIT:    cal_regs.slow_wait_ticks = val[WAIT_W-1:0];
      REG_AVERAGE_CNT:  cal_regs.average_count   = val[AVGC_W-1:0];
      REG_ZERO_CODE:    cal_regs.zero_code       = val;
      REG_MASS_DIVISOR: cal_regs.mass_divisor    = val;
      default: ;
    endcase
  endtask

  // Random register write; waits and counts stay short so runs remain quick
  task automatic random_reg_write();
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    int                    r;
    idx = CFG_IDX_W'($urandom_range(REG_SPEED_FAST, REG_MASS_DIVISOR));
    val = CFG_DATA_W'($urandom);
    r   = $urandom_range(0, 9);
    case (idx)
      REG_FAST_WAIT, REG_SLOW_WAIT:
        val[WAIT_W-1:0] = WAIT_W'((r == 0) ? 0 : (r < 7) ? $urandom_range(1, 4) :
                                  $urandom_range(5, 30));
      REG_AVERAGE_CNT:
        val[AVGC_W-1:0] = AVGC_W'((r < 6) ? 1 : (r < 8) ? $urandom_range(2, 4) :
                                  (r == 8) ? $urandom_range(0, 31) :
                                  $urandom_range(5, 9));
      REG_ZERO_CODE:
        val = (r == 0) ? '0 : (r == 1) ? {RES_W{1'b1}} :
              (r < 5) ? CFG_DATA_W'($urandom_range(0, 4096)) : val;
      REG_MASS_DIVISOR:
        val = (r == 0) ? '0 : (r == 1) ? CFG_DATA_W'(1) : (r == 2) ? {RES_W{1'b1}} :
              (r < 6) ? CFG_DATA_W'($urandom_range(1, 4096)) : val;
      default: ;
    endcase
    write_reg(idx, val);
  endtask

  function automatic logic pick_dout(input data_mode_t m);
    case (m)
      DATA_ONES:  return 1'b1;
      DATA_ZEROS: return 1'b0;
      default:    return 1'($urandom_range(0, 1));
    endcase
  endfunction

  // Feed ticks while a measurement runs, up to the given number of samples
  task automatic advance_until(input int samples, input data_mode_t m, input bit noisy);
    while (rd_phase != PH_IDLE && rd_samples < samples)
      send_tick(noisy ? 1'($urandom_range(0, 1)) : 1'b0, pick_dout(m));
  endtask

  // Whole measurement from idle; optionally a register write after some samples
  task automatic measure(input data_mode_t m, input bit noisy, input int split_at);
    send_tick(1'b1, pick_dout(m));
    if (split_at > 0) begin
      advance_until(split_at, m, noisy);
      if (rd_phase != PH_IDLE) random_reg_write();
    end
    advance_until(AVG_LIMIT + 1, m, noisy);
  endtask

  task automatic test_reset_defaults();
    // idle ticks show the reset speed pin
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    write_reg(REG_FAST_WAIT, CFG_DATA_W'(2));
    measure(DATA_RANDOM, 1'b0, 0);
    measure(DATA_ZEROS, 1'b0, 0);
  endtask

  task automatic test_code_extremes();
    write_reg(REG_ZERO_CODE, '0);
    write_reg(REG_MASS_DIVISOR, CFG_DATA_W'(1));
    measure(DATA_ONES, 1'b0, 0);
    measure(DATA_ZEROS, 1'b0, 0);
    // average equal to and below the zero code
    write_reg(REG_ZERO_CODE, {RES_W{1'b1}});
    write_reg(REG_MASS_DIVISOR, {RES_W{1'b1}});
    measure(DATA_ONES, 1'b0, 0);
    measure(DATA_RANDOM, 1'b0, 0);
    write_reg(REG_ZERO_CODE, CFG_DATA_W'(1));
    measure(DATA_ONES, 1'b0, 0);
    write_reg(REG_ZERO_CODE, '0);
    write_reg(REG_MASS_DIVISOR, CFG_DATA_W'(2));
    measure(DATA_ONES, 1'b0, 0);
  endtask

  task automatic test_special_settings();
    // zero wait, zero count and zero divisor all act as one
    write_reg(REG_FAST_WAIT, '0);
    write_reg(REG_AVERAGE_CNT, '0);
    write_reg(REG_MASS_DIVISOR, '0);
    write_reg(REG_ZERO_CODE, CFG_DATA_W'(5));
    measure(DATA_RANDOM, 1'b0, 0);
    // count above the limit saturates; full-scale sum
    write_reg(REG_FAST_WAIT, {CFG_DATA_W{1'b1}} ^ CFG_DATA_W'(24'hFFFFFE));
    write_reg(REG_AVERAGE_CNT, {CFG_DATA_W{1'b1}});
    measure(DATA_ONES, 1'b0, 0);
    write_reg(REG_AVERAGE_CNT, CFG_DATA_W'(1));
    write_reg(REG_MASS_DIVISOR, CFG_DATA_W'(71));
  endtask

  task automatic test_speed_modes();
    write_reg(REG_SLOW_WAIT, CFG_DATA_W'(3));
    write_reg(REG_FAST_WAIT, {CFG_DATA_W{1'b1}});
    write_reg(REG_SPEED_FAST, '0);
    write_reg(REG_AVERAGE_CNT, CFG_DATA_W'(2));
    measure(DATA_RANDOM, 1'b0, 0);
    write_reg(REG_FAST_WAIT, CFG_DATA_W'(1));
    write_reg(REG_SLOW_WAIT, CFG_DATA_W'(20'hFFFFF));
    write_reg(REG_SPEED_FAST, {CFG_DATA_W{1'b1}});
    measure(DATA_RANDOM, 1'b0, 0);
    write_reg(REG_SLOW_WAIT, CFG_DATA_W'(2));
  endtask

  task automatic test_start_while_busy();
    measure(DATA_RANDOM, 1'b1, 0);
    write_reg(REG_AVERAGE_CNT, CFG_DATA_W'(1));
    measure(DATA_ONES, 1'b1, 0);
  endtask

  task automatic test_midrun_writes();
    // wait change only applies from the next load; lower count ends early
    write_reg(REG_AVERAGE_CNT, CFG_DATA_W'(3));
    send_tick(1'b1, 1'b0);
    advance_until(1, DATA_RANDOM, 1'b0);
    write_reg(REG_FAST_WAIT, CFG_DATA_W'(5));
    write_reg(REG_AVERAGE_CNT, CFG_DATA_W'(1));
    advance_until(AVG_LIMIT + 1, DATA_RANDOM, 1'b0);
    // speed and calibration changed between samples
    write_reg(REG_AVERAGE_CNT, CFG_DATA_W'(2));
    send_tick(1'b1, 1'b1);
    advance_until(1, DATA_ONES, 1'b0);
    write_reg(REG_SPEED_FAST, '0);
    write_reg(REG_ZERO_CODE, CFG_DATA_W'(100));
    write_reg(REG_MASS_DIVISOR, CFG_DATA_W'(13));
    advance_until(AVG_LIMIT + 1, DATA_ONES, 1'b0);
    write_reg(REG_SPEED_FAST, CFG_DATA_W'(1));
    write_reg(REG_FAST_WAIT, CFG_DATA_W'(3));
  endtask

  task automatic test_random_ticks();
    int         item_goal;
    int         r;
    data_mode_t m;
    item_goal = items_sent + 300;
    while (items_sent < item_goal) begin
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) random_reg_write();
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(0, 4)) send_tick(1'b0, 1'($urandom_range(0, 1)));
      r = $urandom_range(0, 7);
      m = (r == 0) ? DATA_ONES : (r == 1) ? DATA_ZEROS : DATA_RANDOM;
      measure(m, $urandom_range(0, 2) == 0,
              ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0);
    end
  endtask

  initial begin
    rst               = 1'b1;
    in_valid          = 1'b0;
    start_req         = 1'b0;
    dout_level        = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = REG_SPEED_FAST;
    cfg_data          = '0;
    items_sent        = 0;
    tx_calm           = 1'b0;
    rx_calm           = 1'b0;
    tx_holding        = 1'b0;
    reset_model();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_code_extremes();
    test_special_settings();
    test_speed_modes();
    test_start_while_busy();
    test_midrun_writes();
    test_random_ticks();

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
